// ----- rtl/wpd_pkg.sv -----
// shared types and constants for the wav pcm16 parser and downmixer
package wpd_pkg;

  typedef enum logic [3:0] {
    P_RIFF   = 4'd0,
    P_RSIZE  = 4'd1,
    P_WAVE   = 4'd2,
    P_TAG    = 4'd3,
    P_SZFMT  = 4'd4,
    P_SZDATA = 4'd5,
    P_SZSKIP = 4'd6,
    P_FMT    = 4'd7,
    P_DATA   = 4'd8,
    P_SKIP   = 4'd9,
    P_PAD    = 4'd10,
    P_HALT   = 4'd11
  } phase_t;

  typedef enum logic [1:0] {
    SQ_IDLE   = 2'd0,
    SQ_DIV    = 2'd1,
    SQ_SAMPLE = 2'd2,
    SQ_STATUS = 2'd3
  } seq_t;

  localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;
  localparam logic [31:0] RIFF_TAG = 32'h4646_4952;
  localparam logic [31:0] WAVE_TAG = 32'h4556_4157;

  localparam logic [3:0] ST_OK         = 4'd0;
  localparam logic [3:0] ST_NO_RIFF    = 4'd1;
  localparam logic [3:0] ST_NO_WAVE    = 4'd2;
  localparam logic [3:0] ST_TRUNC_HDR  = 4'd3;
  localparam logic [3:0] ST_NOT_PCM16  = 4'd4;
  localparam logic [3:0] ST_ODD_DATA   = 4'd5;
  localparam logic [3:0] ST_TRUNC_SMP  = 4'd6;
  localparam logic [3:0] ST_MISSING    = 4'd7;
  localparam logic [3:0] ST_BAD_ORDER  = 4'd8;
  localparam logic [3:0] ST_SHORT_FMT  = 4'd9;

  localparam logic [15:0] FMT_HDR_LEN = 16'd16;
  localparam logic [15:0] PCM_CODE    = 16'd1;
  localparam logic [31:0] PCM_BITS    = 32'd16;

endpackage

// ----- rtl/wpd_div.sv -----
// iterative signed-by-unsigned divider, one quotient bit per cycle
module wpd_div #(
  parameter int SUM_W = 20
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic signed [SUM_W-1:0] dividend,
  input  logic [15:0]             divisor,
  output logic                    busy,
  output logic                    done,
  output logic [15:0]             quotient
);

  localparam int CNT_W = $clog2(SUM_W + 1);

  logic [SUM_W-1:0] quo;
  logic [16:0]      rem;
  logic [15:0]      dsr;
  logic             neg;
  logic [CNT_W-1:0] cnt;
  logic [16:0]      rem_sh;
  logic [16:0]      rem_sub;
  logic             fit;
  logic [SUM_W-1:0] quo_step;
  logic [SUM_W-1:0] quo_signed;

  assign rem_sh   = {rem[15:0], quo[SUM_W-1]};
  assign rem_sub  = rem_sh - {1'b0, dsr};
  assign fit      = rem_sh >= {1'b0, dsr};
  assign quo_step = {quo[SUM_W-2:0], fit};
  assign quo_signed = neg ? (~quo_step + 1'b1) : quo_step;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(SUM_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg <= dividend[SUM_W-1];
      quo <= dividend[SUM_W-1] ? (~dividend + 1'b1) : dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (busy) begin
      rem <= fit ? rem_sub : rem_sh;
      quo <= quo_step;
      if (cnt == CNT_W'(1)) begin
        quotient <= quo_signed[15:0];
      end
    end
  end

endmodule

// ----- rtl/wav_pcm16_parse_downmix_top.sv -----
// top level: riff/wave byte parser with pcm16 channel downmix
// One file byte is taken per word on the input side. Header, size and skipped
// bytes are absorbed without stalling the input; the block is then ready again.
// The byte that completes a data frame starts a shared restoring divider that
// produces one quotient bit per cycle, so that byte keeps the input stalled
// through the divide and until every result word for it has been handed out.
// A byte marked end_of_file produces a status word with is_last set after any
// sample word, and all parser state returns to its reset value for the next
// file. in_stall is high from the accepting edge until every result word for
// that byte has been taken.
module wav_pcm16_parse_downmix_top
  import wpd_pkg::*;
#(
  parameter int MAX_CHANNELS = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_byte,
  input  logic               end_of_file,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               kind,
  output logic signed [15:0] mono_sample,
  output logic [3:0]         status,
  output logic [30:0]        rate_hz,
  output logic [15:0]        source_channels,
  output logic               is_last
);

  // frame sum wide enough for MAX_CHANNELS full-scale samples plus sign
  localparam int SUM_W = 17 + $clog2(MAX_CHANNELS);

  // parser state
  phase_t                  phase, phase_next;
  logic [2:0]              fbc, fbc_next;
  logic [31:0]             fshift, fshift_next;
  logic [31:0]             crem, crem_next;
  logic                    codd, codd_next;
  logic [15:0]             fcode, fcode_next;
  logic [15:0]             chtot, chtot_next;
  logic [31:0]             rate, rate_next;
  logic                    fmt_seen, fmt_seen_next;
  logic                    any_smp, any_smp_next;
  logic [7:0]              lowb, lowb_next;
  logic [15:0]             chidx, chidx_next;
  logic signed [SUM_W-1:0] fsum, fsum_next;
  logic [3:0]              err, err_next;

  // sequencer and result holding registers
  seq_t        seq, seq_next;
  logic        eof_pend, eof_pend_next;
  logic [3:0]  st_hold, st_calc;
  logic [30:0] rate_hold, rate_keep;
  logic [15:0] ch_hold, ch_keep;

  logic                    accept;
  logic                    div_go;
  logic signed [SUM_W-1:0] div_num;
  logic                    div_busy;
  logic                    div_done;
  logic [15:0]             div_q;

  assign accept = in_valid && !in_stall;

  // parser step, evaluated for the byte being accepted
  always_comb begin
    logic [31:0]             sh_new;
    logic [31:0]             bits;
    logic [3:0]              off;
    logic signed [SUM_W-1:0] sum_new;
    logic [15:0]             idx_new;
    logic [15:0]             smp;
    phase_next    = phase;
    fbc_next      = fbc;
    fshift_next   = fshift;
    crem_next     = crem;
    codd_next     = codd;
    fcode_next    = fcode;
    chtot_next    = chtot;
    rate_next     = rate;
    fmt_seen_next = fmt_seen;
    any_smp_next  = any_smp;
    lowb_next     = lowb;
    chidx_next    = chidx;
    fsum_next     = fsum;
    err_next      = err;
    div_go        = 1'b0;
    div_num       = fsum;
    st_calc       = ST_OK;
    rate_keep     = rate[30:0];
    ch_keep       = chtot;
    sh_new  = fshift | ({24'd0, in_byte} << {fbc[1:0], 3'b000});
    bits    = '0;
    off     = chidx[3:0];
    smp     = {in_byte, lowb};
    sum_new = fsum + {{(SUM_W-16){smp[15]}}, smp};
    idx_new = chidx + 16'd1;
    if (accept) begin
      case (phase)
        P_RIFF, P_WAVE: begin
          if (in_byte != 8'(((phase == P_RIFF) ? RIFF_TAG : WAVE_TAG) >>
                            {fbc[1:0], 3'b000})) begin
            err_next   = (phase == P_RIFF) ? ST_NO_RIFF : ST_NO_WAVE;
            phase_next = P_HALT;
          end else if (fbc == 3'd3) begin
            fbc_next   = '0;
            phase_next = (phase == P_RIFF) ? P_RSIZE : P_TAG;
          end else begin
            fbc_next = fbc + 3'd1;
          end
        end
        P_RSIZE: begin
          if (fbc == 3'd3) begin
            fbc_next   = '0;
            phase_next = P_WAVE;
          end else begin
            fbc_next = fbc + 3'd1;
          end
        end
        P_TAG: begin
          if (fbc == 3'd3) begin
            phase_next  = (sh_new == TAG_FMT) ? P_SZFMT :
                          (sh_new == TAG_DATA) ? P_SZDATA : P_SZSKIP;
            fshift_next = '0;
            fbc_next    = '0;
          end else begin
            fshift_next = sh_new;
            fbc_next    = fbc + 3'd1;
          end
        end
        P_SZFMT, P_SZDATA, P_SZSKIP: begin
          if (fbc != 3'd3) begin
            fshift_next = sh_new;
            fbc_next    = fbc + 3'd1;
          end else begin
            fshift_next = '0;
            fbc_next    = '0;
            codd_next   = sh_new[0];
            if (phase == P_SZFMT) begin
              if (sh_new < 32'(FMT_HDR_LEN)) begin
                err_next   = ST_SHORT_FMT;
                phase_next = P_HALT;
              end else begin
                fcode_next = '0;
                chtot_next = '0;
                rate_next  = '0;
                chidx_next = '0;
                crem_next  = sh_new - 32'(FMT_HDR_LEN);
                phase_next = P_FMT;
              end
            end else if (phase == P_SZDATA) begin
              if (!fmt_seen) begin
                err_next   = ST_BAD_ORDER;
                phase_next = P_HALT;
              end else if (sh_new[0]) begin
                err_next   = ST_ODD_DATA;
                phase_next = P_HALT;
              end else begin
                crem_next  = sh_new;
                chidx_next = '0;
                fsum_next  = '0;
                phase_next = (sh_new == 32'd0) ? P_TAG : P_DATA;
              end
            end else begin
              crem_next  = sh_new;
              if (sh_new == 32'd0) begin
                phase_next = sh_new[0] ? P_PAD : P_TAG;
              end else begin
                phase_next = P_SKIP;
              end
            end
          end
        end
        P_FMT: begin
          if (chidx[15:4] == '0) begin
            if (off < 4'd2) begin
              fcode_next = fcode | ({8'd0, in_byte} << {off[0], 3'b000});
            end else if (off < 4'd4) begin
              chtot_next = chtot | ({8'd0, in_byte} << {off[0], 3'b000});
            end else if (off < 4'd8) begin
              rate_next = rate | ({24'd0, in_byte} << {off[1:0], 3'b000});
            end else if (off >= 4'd14) begin
              fshift_next = fshift | ({24'd0, in_byte} << {off[0], 3'b000});
            end
            chidx_next = idx_new;
            if (off == 4'd15) begin
              bits        = fshift_next;
              fshift_next = '0;
              if (fcode_next != PCM_CODE || bits != PCM_BITS) begin
                err_next   = ST_NOT_PCM16;
                phase_next = P_HALT;
              end else if (chtot_next > 16'(MAX_CHANNELS)) begin
                err_next   = ST_BAD_ORDER;
                phase_next = P_HALT;
              end else begin
                fmt_seen_next = 1'b1;
                if (crem == 32'd0) begin
                  phase_next = codd ? P_PAD : P_TAG;
                end
              end
            end
          end else begin
            crem_next = crem - 32'd1;
            if (crem == 32'd1) begin
              phase_next = codd ? P_PAD : P_TAG;
            end
          end
        end
        P_DATA: begin
          if (!crem[0]) begin
            lowb_next = in_byte;
          end else begin
            any_smp_next = 1'b1;
            if (chtot != 16'd0) begin
              if (idx_new >= chtot) begin
                div_go     = 1'b1;
                div_num    = sum_new;
                fsum_next  = '0;
                chidx_next = '0;
              end else begin
                fsum_next  = sum_new;
                chidx_next = idx_new;
              end
            end
          end
          crem_next = crem - 32'd1;
          if (crem == 32'd1) begin
            chidx_next = '0;
            fsum_next  = '0;
            phase_next = codd ? P_PAD : P_TAG;
          end
        end
        P_SKIP: begin
          crem_next = crem - 32'd1;
          if (crem == 32'd1) begin
            phase_next = codd ? P_PAD : P_TAG;
          end
        end
        P_PAD: begin
          phase_next = P_TAG;
        end
        default: begin
        end
      endcase

      // closing status, judged on the state this byte leaves behind
      if (err_next != ST_OK) begin
        st_calc = err_next;
      end else if (phase_next == P_RIFF) begin
        st_calc = ST_NO_RIFF;
      end else if (phase_next == P_WAVE) begin
        st_calc = ST_NO_WAVE;
      end else if (phase_next inside {P_RSIZE, P_SZFMT, P_SZDATA, P_SZSKIP} ||
                   (phase_next == P_TAG && fbc_next != 3'd0) ||
                   (phase_next == P_FMT && chidx_next < FMT_HDR_LEN)) begin
        st_calc = ST_TRUNC_HDR;
      end else if (phase_next == P_DATA) begin
        st_calc = ST_TRUNC_SMP;
      end else if (rate_next == 32'd0 || rate_next[31] || chtot_next == 16'd0 ||
                   !any_smp_next) begin
        st_calc = ST_MISSING;
      end

      // rate and channel count for the status word, taken before the clear
      rate_keep = rate_next[30:0];
      ch_keep   = chtot_next;

      if (end_of_file) begin
        phase_next    = P_RIFF;
        fbc_next      = '0;
        fshift_next   = '0;
        crem_next     = '0;
        codd_next     = 1'b0;
        fcode_next    = '0;
        chtot_next    = '0;
        rate_next     = '0;
        fmt_seen_next = 1'b0;
        any_smp_next  = 1'b0;
        lowb_next     = '0;
        chidx_next    = '0;
        fsum_next     = '0;
        err_next      = ST_OK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= P_RIFF;
      fbc      <= '0;
      fshift   <= '0;
      crem     <= '0;
      codd     <= 1'b0;
      fcode    <= '0;
      chtot    <= '0;
      rate     <= '0;
      fmt_seen <= 1'b0;
      any_smp  <= 1'b0;
      lowb     <= '0;
      chidx    <= '0;
      fsum     <= '0;
      err      <= ST_OK;
      seq      <= SQ_IDLE;
      eof_pend <= 1'b0;
    end else begin
      phase    <= phase_next;
      fbc      <= fbc_next;
      fshift   <= fshift_next;
      crem     <= crem_next;
      codd     <= codd_next;
      fcode    <= fcode_next;
      chtot    <= chtot_next;
      rate     <= rate_next;
      fmt_seen <= fmt_seen_next;
      any_smp  <= any_smp_next;
      lowb     <= lowb_next;
      chidx    <= chidx_next;
      fsum     <= fsum_next;
      err      <= err_next;
      seq      <= seq_next;
      eof_pend <= eof_pend_next;
    end
  end

  // status word fields are captured from the pre-clear state
  always_ff @(posedge clk) begin
    if (accept && end_of_file) begin
      st_hold   <= st_calc;
      rate_hold <= rate_keep;
      ch_hold   <= ch_keep;
    end
  end

  // sequencer: next state
  always_comb begin
    seq_next      = seq;
    eof_pend_next = eof_pend;
    case (seq)
      SQ_IDLE: begin
        if (accept) begin
          eof_pend_next = end_of_file;
          if (div_go) begin
            seq_next = SQ_DIV;
          end else if (end_of_file) begin
            seq_next = SQ_STATUS;
          end
        end
      end
      SQ_DIV: begin
        if (div_done) begin
          seq_next = SQ_SAMPLE;
        end
      end
      SQ_SAMPLE: begin
        if (!out_stall) begin
          seq_next = eof_pend ? SQ_STATUS : SQ_IDLE;
        end
      end
      SQ_STATUS: begin
        if (!out_stall) begin
          seq_next      = SQ_IDLE;
          eof_pend_next = 1'b0;
        end
      end
      default: begin
        seq_next = SQ_IDLE;
      end
    endcase
  end

  // sequencer: outputs
  always_comb begin
    in_stall        = 1'b1;
    out_valid       = 1'b0;
    kind            = 1'b0;
    mono_sample     = '0;
    status          = ST_OK;
    rate_hz         = '0;
    source_channels = '0;
    is_last         = 1'b0;
    case (seq)
      SQ_IDLE: begin
        in_stall = 1'b0;
      end
      SQ_DIV: begin
      end
      SQ_SAMPLE: begin
        out_valid   = 1'b1;
        mono_sample = div_q;
      end
      SQ_STATUS: begin
        out_valid       = 1'b1;
        kind            = 1'b1;
        status          = st_hold;
        rate_hz         = rate_hold;
        source_channels = ch_hold;
        is_last         = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // shared divider for the frame average
  wpd_div #(
    .SUM_W(SUM_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_go),
    .dividend (div_num),
    .divisor  (chtot),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q)
  );

`ifndef ASSERT_OFF
  // no new byte while a result word is on offer
  a_stall_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("byte taken while result pending");

  // divider only runs while the sequencer waits on it
  a_div_seq: assert property (@(posedge clk) disable iff (rst)
    div_busy |-> (seq == SQ_DIV))
    else $error("divider busy outside divide state");

  // a file's status word leaves the parser back at the start of a file
  a_eof_clear: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && is_last) |-> (phase == P_RIFF && err == ST_OK))
    else $error("parser not cleared after status");
`endif

endmodule

// ----- tb/wav_pcm16_parse_downmix_checker.sv -----
// checker for the wav pcm16 parser: predicts result words and compares them
`timescale 1ns / 1ps
module wav_pcm16_parse_downmix_checker
  import wpd_pkg::*;
#(
  parameter int MAX_CHANNELS = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [7:0]         in_byte,
  input  logic               end_of_file,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic               kind,
  input  logic signed [15:0] mono_sample,
  input  logic [3:0]         status,
  input  logic [30:0]        rate_hz,
  input  logic [15:0]        source_channels,
  input  logic               is_last,
  output int                 fail_count,
  output int                 pending
);

  typedef struct packed {
    logic        kind;
    logic [15:0] sample;
    logic [3:0]  status;
    logic [30:0] rate;
    logic [15:0] chans;
    logic        last;
  } word_t;

  word_t expected_words[$];

  phase_t      ph;
  logic [2:0]  fcnt;
  logic [31:0] shreg, remain;
  logic        odd, fmt_ok, got_sample;
  logic [15:0] fcode, nchan, idx;
  logic [31:0] rate;
  logic [7:0]  lowb;
  int          fsum;
  logic [3:0]  err;

  assign pending = expected_words.size();

  function automatic logic [7:0] tag_byte(logic [31:0] t, logic [2:0] i);
    return t[8*i[1:0] +: 8];
  endfunction

  task automatic clear_parser();
    ph = P_RIFF; fcnt = '0; shreg = '0; remain = '0; odd = 1'b0; fcode = '0;
    nchan = '0; rate = '0; fmt_ok = 1'b0; got_sample = 1'b0; lowb = '0; idx = '0;
    fsum = 0; err = ST_OK;
  endtask

  task automatic halt_with(logic [3:0] c);
    err = c; ph = P_HALT;
  endtask

  task automatic close_body();
    ph = odd ? P_PAD : P_TAG;
  endtask

  task automatic expect_word(word_t w);
    expected_words = {expected_words, w};
  endtask

  function automatic logic [3:0] file_status();
    if (err != ST_OK) return err;
    case (ph)
      P_RIFF: return ST_NO_RIFF;
      P_WAVE: return ST_NO_WAVE;
      P_RSIZE, P_SZFMT, P_SZDATA, P_SZSKIP: return ST_TRUNC_HDR;
      P_TAG: if (fcnt != 0) return ST_TRUNC_HDR;
      P_FMT: if (idx < 16) return ST_TRUNC_HDR;
      P_DATA: return ST_TRUNC_SMP;
      default: ;
    endcase
    if (rate == 0 || rate[31] || nchan == 0 || !got_sample) return ST_MISSING;
    return ST_OK;
  endfunction

  task automatic predict_byte(logic [7:0] b, logic eof);
    logic [31:0] size;
    logic [15:0] raw;
    int s, avg;
    word_t w;
    case (ph)
      P_RIFF, P_WAVE: begin
        if (b != tag_byte(ph == P_RIFF ? RIFF_TAG : WAVE_TAG, fcnt))
          halt_with(ph == P_RIFF ? ST_NO_RIFF : ST_NO_WAVE);
        else begin
          fcnt++;
          if (fcnt == 4) begin
            fcnt = '0;
            ph = (ph == P_RIFF) ? P_RSIZE : P_TAG;
          end
        end
      end
      P_RSIZE: begin
        fcnt++;
        if (fcnt == 4) begin fcnt = '0; ph = P_WAVE; end
      end
      P_TAG: begin
        shreg |= 32'(b) << (8 * fcnt[1:0]);
        fcnt++;
        if (fcnt == 4) begin
          ph = (shreg == TAG_FMT) ? P_SZFMT : (shreg == TAG_DATA) ? P_SZDATA : P_SZSKIP;
          shreg = '0; fcnt = '0;
        end
      end
      P_SZFMT, P_SZDATA, P_SZSKIP: begin
        shreg |= 32'(b) << (8 * fcnt[1:0]);
        fcnt++;
        if (fcnt == 4) begin
          size = shreg; shreg = '0; fcnt = '0; odd = size[0];
          if (ph == P_SZFMT) begin
            if (size < 16) halt_with(ST_SHORT_FMT);
            else begin
              fcode = '0; nchan = '0; rate = '0; idx = '0;
              remain = size - 32'd16; ph = P_FMT;
            end
          end else if (ph == P_SZDATA) begin
            if (!fmt_ok) halt_with(ST_BAD_ORDER);
            else if (odd) halt_with(ST_ODD_DATA);
            else begin
              remain = size; idx = '0; fsum = 0;
              if (size == 0) close_body(); else ph = P_DATA;
            end
          end else begin
            remain = size;
            if (size == 0) close_body(); else ph = P_SKIP;
          end
        end
      end
      P_FMT: begin
        if (idx < 16) begin
          if (idx < 2) fcode |= 16'(b) << (8 * idx);
          else if (idx < 4) nchan |= 16'(b) << (8 * (idx - 2));
          else if (idx < 8) rate |= 32'(b) << (8 * (idx - 4));
          else if (idx >= 14) shreg |= 32'(b) << (8 * (idx - 14));
          idx++;
          if (idx == 16) begin
            size = shreg; shreg = '0;
            if (fcode != PCM_CODE || size != PCM_BITS) halt_with(ST_NOT_PCM16);
            else if (nchan > MAX_CHANNELS) halt_with(ST_BAD_ORDER);
            else begin
              fmt_ok = 1'b1;
              if (remain == 0) close_body();
            end
          end
        end else begin
          remain--;
          if (remain == 0) close_body();
        end
      end
      P_DATA: begin
        if (!remain[0]) lowb = b;
        else begin
          raw = {b, lowb};
          s = $signed(raw);
          got_sample = 1'b1;
          if (nchan != 0) begin
            fsum += s; idx++;
            if (idx >= nchan) begin
              avg = fsum / int'(nchan);
              w = '0; w.sample = avg[15:0];
              expect_word(w);
              idx = '0; fsum = 0;
            end
          end
        end
        remain--;
        if (remain == 0) begin idx = '0; fsum = 0; close_body(); end
      end
      P_SKIP: begin
        remain--;
        if (remain == 0) close_body();
      end
      P_PAD: ph = P_TAG;
      default: ;
    endcase
    if (eof) begin
      w = '0; w.kind = 1'b1; w.status = file_status(); w.rate = rate[30:0];
      w.chans = nchan; w.last = 1'b1;
      expect_word(w);
      clear_parser();
    end
  endtask

  word_t got, want;

  always @(posedge clk) begin
    if (rst) begin
      clear_parser();
      expected_words.delete();
      fail_count <= 0;
    end else begin
      if (in_valid && !in_stall) predict_byte(in_byte, end_of_file);
      if (out_valid && !out_stall) begin
        got = {kind, mono_sample, status, rate_hz, source_channels, is_last};
        if (expected_words.size() == 0) begin
          if (fail_count < 10) $display("unexpected word %h", got);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_words.pop_front();
          if (got != want) begin
            if (fail_count < 10)
              $display({"mismatch: expected k%0d s%0d st%0d r%0d c%0d l%0d, ",
                        "got k%0d s%0d st%0d r%0d c%0d l%0d"},
                       want.kind, $signed(want.sample), want.status, want.rate,
                       want.chans, want.last, got.kind, $signed(got.sample),
                       got.status, got.rate, got.chans, got.last);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

// ----- tb/wav_pcm16_parse_downmix_top_tb.sv -----
// testbench top for the wav pcm16 parser: builds byte streams and gives the verdict
`timescale 1ns / 1ps
module wav_pcm16_parse_downmix_top_tb;
  import wpd_pkg::*;

  logic               clk = 0;
  logic               rst = 1;
  logic               in_valid = 0;
  logic               in_stall;
  logic [7:0]         in_byte = 0;
  logic               end_of_file = 0;
  logic               out_valid;
  logic               out_stall = 0;
  logic               kind;
  logic signed [15:0] mono_sample;
  logic [3:0]         status;
  logic [30:0]        rate_hz;
  logic [15:0]        source_channels;
  logic               is_last;
  int                 fail_count;
  int                 pending;

  // byte stream of the file under construction
  logic [7:0] file_bytes[$];
  int         bytes_sent;
  // set while the receiver is held off for a long stretch
  logic       long_hold = 0;

  always #2 clk = ~clk;

  wav_pcm16_parse_downmix_top uut (.*);

  wav_pcm16_parse_downmix_checker chk (.*);

  // receiver: stall pattern of its own, with a long hold-off on request
  initial begin
    int mode;
    mode = 0;
    forever begin
      @(posedge clk);
      if (long_hold) out_stall <= 1;
      else begin
        if ($urandom_range(0, 63) == 0) mode = $urandom_range(0, 2);
        case (mode)
          0: out_stall <= 0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          default: out_stall <= ($urandom_range(0, 1) == 0);
        endcase
      end
    end
  end

  task automatic add_byte(logic [7:0] b);
    file_bytes = {file_bytes, b};
  endtask

  task automatic put32(logic [31:0] v);
    for (int i = 0; i < 4; i++) add_byte(v[8*i +: 8]);
  endtask

  task automatic put16(logic [15:0] v);
    add_byte(v[7:0]);
    add_byte(v[15:8]);
  endtask

  // fmt chunk with the given code, channels, rate, bits and extra tail bytes
  task automatic put_fmt(logic [15:0] code, logic [15:0] ch, logic [31:0] rate,
                         logic [15:0] bits, int extra);
    put32(TAG_FMT);
    put32(32'(16 + extra));
    put16(code); put16(ch); put32(rate); put32($urandom); put16(16'($urandom));
    put16(bits);
    for (int i = 0; i < extra; i++) add_byte(8'($urandom));
    if (extra % 2) add_byte(8'($urandom));
  endtask

  // sample with a bias towards the extremes
  function automatic logic [15:0] pick_sample();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'hffff;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic put_data(int nbytes);
    put32(TAG_DATA);
    put32(nbytes);
    for (int i = 0; i < nbytes / 2; i++) put16(pick_sample());
    if (nbytes % 2) add_byte(8'($urandom));
  endtask

  task automatic put_skip(int n);
    put32($urandom);
    put32(n);
    for (int i = 0; i < n + (n % 2); i++) add_byte(8'($urandom));
  endtask

  task automatic riff_head();
    file_bytes.delete();
    put32(RIFF_TAG); put32($urandom); put32(WAVE_TAG);
  endtask

  // send the stream in bursts; cut marks the byte carrying end_of_file
  task automatic send_file(int cut);
    int gap;
    gap = 0;
    for (int i = 0; i <= cut; i++) begin
      if (gap == 0 && $urandom_range(0, 7) == 0) begin
        in_valid <= 0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
      in_byte <= file_bytes[i];
      end_of_file <= (i == cut);
      in_valid <= 1;
      @(posedge clk);
      while (in_stall) @(posedge clk);
      bytes_sent++;
      gap = (gap == 0) ? $urandom_range(0, 12) : gap - 1;
    end
    in_valid <= 0;
    end_of_file <= 0;
  endtask

  task automatic send_whole();
    send_file(file_bytes.size() - 1);
  endtask

  task automatic drain();
    while (pending != 0) @(posedge clk);
  endtask

  // random well-formed file with occasional damage
  task automatic random_file();
    int ch, cut;
    ch = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 8);
    riff_head();
    if ($urandom_range(0, 3) == 0) put_skip($urandom_range(0, 5));
    put_fmt(16'd1, 16'(ch),
            ($urandom_range(0, 9) == 0) ? 32'h8000_0000 | $urandom : $urandom_range(1, 96000),
            16'd16, ($urandom_range(0, 2) == 0) ? $urandom_range(0, 3) : 0);
    put_data(2 * ch * $urandom_range(0, 4) + 2 * $urandom_range(0, 1));
    if ($urandom_range(0, 3) == 0) put_data(2 * $urandom_range(0, 6));
    cut = file_bytes.size() - 1;
    if ($urandom_range(0, 5) == 0) cut = $urandom_range(0, cut);
    if ($urandom_range(0, 9) == 0) file_bytes[$urandom_range(0, cut)] = 8'($urandom);
    send_file(cut);
  endtask

  initial begin
    bytes_sent = 0;
    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: good stereo file with extreme samples
    riff_head(); put_fmt(16'd1, 16'd2, 48000, 16'd16, 0);
    put32(TAG_DATA); put32(8);
    put16(16'h8000); put16(16'h8000); put16(16'h7fff); put16(16'hffff);
    send_whole();
    // bad riff, bad wave, truncated header
    riff_head(); file_bytes[1] = 8'h00; send_file(2);
    riff_head(); file_bytes[9] = 8'hff; send_file(9);
    riff_head(); send_file(5);
    // not pcm16, too many channels, short fmt
    riff_head(); put_fmt(16'd3, 16'd1, 8000, 16'd16, 0); send_whole();
    riff_head(); put_fmt(16'd1, 16'd9, 8000, 16'd16, 0); send_whole();
    riff_head(); put32(TAG_FMT); put32(15); send_whole();
    // data before fmt, odd data size
    riff_head(); put_data(4); send_whole();
    riff_head(); put_fmt(16'd1, 16'd1, 8000, 16'd16, 1); put_data(3); send_whole();
    drain();

    // pressure: long receiver hold-off while bytes keep coming
    long_hold <= 1;
    fork
      begin
        riff_head(); put_fmt(16'd1, 16'd1, 44100, 16'd16, 0); put_data(40); send_whole();
      end
      begin
        repeat (300) @(posedge clk);
        long_hold <= 0;
      end
    join
    drain();

    while (bytes_sent < 750) begin
      random_file();
      if ($urandom_range(0, 7) == 0) drain();
    end

    drain();
    repeat (100) @(posedge clk);
    if (fail_count == 0 && pending == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  initial begin
    #20ms;
    $display("tb: failure");
    $finish;
  end

endmodule
